// File: rtl/core/ins_pkg.sv
// Shared types and constants for the insertion sorter.
package ins_pkg;

    localparam int DEPTH = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [31:0] value;
        logic               final_item;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_run;
        logic               overflowed;
    } out_res_t;

    // Link from one cell to its neighbor.
    typedef struct packed {
        logic               valid;
        logic               gt;
        logic signed [31:0] value;
    } cell_link_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic               insert;
        logic               drain;
        logic signed [31:0] value;
    } cell_ctrl_t;

endpackage

// File: rtl/core/insertion_sorter_unit.sv
// Top level: stable ascending insertion sorter built from a chain of cells.
// A final request is followed by N results, one per stored entry, on N
// consecutive cycles, registered through drain_reg and then res_reg.
// Throughput: 1 request per cycle while loading; busy holds for the drain,
// which shifts the chain out through cell 0 one entry per cycle.
// Reset clears the count, overflow flag, cell valid bits and drain state.
module insertion_sorter_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ins_pkg::in_req_t  req,
    output logic              res_valid,
    output ins_pkg::out_res_t res
);

    // Fill count, overflow flag and drain sequencing.
    logic [ins_pkg::CNT_W-1:0] count_reg;
    logic [ins_pkg::CNT_W-1:0] count_next;
    logic [ins_pkg::CNT_W-1:0] remain_reg;
    logic [ins_pkg::CNT_W-1:0] remain_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic                      drain_reg;
    logic                      drain_next;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    ins_pkg::out_res_t         res_reg;
    ins_pkg::out_res_t         res_next;

    logic                      accept;
    logic                      full;
    ins_pkg::cell_ctrl_t       ctrl;
    ins_pkg::cell_link_t       links [ins_pkg::DEPTH];
    ins_pkg::cell_link_t       lefts [ins_pkg::DEPTH];
    ins_pkg::cell_link_t       rights[ins_pkg::DEPTH];

    assign accept = start && !drain_reg;
    assign full   = (count_reg == ins_pkg::CNT_W'(ins_pkg::DEPTH));

    // A request is dropped when the chain is full; only the flag records it.
    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = drain_reg;
    assign ctrl.value  = req.value;

    // Cell 0 sees a virtual left neighbor that is valid and never greater,
    // so it takes the new value whenever its own entry is greater or empty.
    // The last cell shifts in an empty entry during drain.
    genvar gi;
    generate
        for (gi = 0; gi < ins_pkg::DEPTH; gi++)
        begin : g_chain
            if (gi == 0)
            begin : g_first
                assign lefts[gi] = '{valid: 1'b1, gt: 1'b0, value: '0};
            end
            else
            begin : g_mid
                assign lefts[gi] = links[gi-1];
            end

            if (gi == ins_pkg::DEPTH - 1)
            begin : g_last
                assign rights[gi] = '{valid: 1'b0, gt: 1'b0, value: '0};
            end
            else
            begin : g_inner
                assign rights[gi] = links[gi+1];
            end

            ins_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .left  (lefts[gi]),
                .right (rights[gi]),
                .link  (links[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        remain_next    = remain_reg;
        ovf_next       = ovf_reg;
        drain_next     = drain_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        if (drain_reg)
        begin
            // Emit the head of the chain; the cells shift toward cell 0.
            res_valid_next        = 1'b1;
            res_next.sorted_value = links[0].value;
            res_next.end_of_run   = (remain_reg == ins_pkg::CNT_W'(1));
            res_next.overflowed   = ovf_reg;
            remain_next           = remain_reg - ins_pkg::CNT_W'(1);
            if (remain_reg == ins_pkg::CNT_W'(1))
            begin
                drain_next = 1'b0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + ins_pkg::CNT_W'(1);
            end
            // The final request starts the drain of the whole set.
            if (req.final_item)
            begin
                drain_next  = 1'b1;
                remain_next = count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            remain_reg    <= '0;
            ovf_reg       <= 1'b0;
            drain_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            ovf_reg       <= ovf_next;
            drain_reg     <= drain_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy      = drain_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/core/ins_cell.sv
// One storage cell of the insertion chain.
module ins_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  ins_pkg::cell_ctrl_t ctrl,
    input  ins_pkg::cell_link_t left,
    input  ins_pkg::cell_link_t right,
    output ins_pkg::cell_link_t link
);

    logic               valid_reg;
    logic               valid_next;
    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               gt;

    // Stored entry strictly greater than the incoming value: it moves right.
    assign gt = valid_reg && (value_reg > ctrl.value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (left.valid && left.gt)
            begin
                valid_next = 1'b1;
                value_next = left.value;
            end
            else if (left.valid && (gt || !valid_reg))
            begin
                valid_next = 1'b1;
                value_next = ctrl.value;
            end
        end
        else if (ctrl.drain)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

endmodule
